### hdl/debug_packet_binary_load_macros.svh
// Assertion helpers shared by the block.
`ifndef DEBUG_PACKET_BINARY_LOAD_MACROS_SVH
`define DEBUG_PACKET_BINARY_LOAD_MACROS_SVH

// Implication checked on every rising edge, ignored while reset is high.
`define DPBL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising edge, reset included.
`define DPBL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/dpbl_pkg.sv
package dpbl_pkg;

   localparam int STAGE_DEPTH_DEF = 128;
   localparam logic [31:0] SPACE_MASK_RST = 32'h00ff_0000;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_ETX    = 8'h03;
   localparam logic [7:0] CH_ESC    = 8'h7d;
   localparam logic [7:0] CH_X      = 8'h58;
   localparam logic [7:0] CH_P      = 8'h50;
   localparam logic [7:0] CH_S      = 8'h73;
   localparam logic [7:0] CH_C      = 8'h63;
   localparam logic [7:0] ESC_XOR   = 8'h20;

   typedef enum logic [1:0] {FR_IDLE, FR_BODY, FR_CSH, FR_CSL} frame_type;
   typedef enum logic [1:0] {BP_CMD, BP_ADDR, BP_SIZE, BP_DATA} body_type;
   typedef enum logic [1:0] {RP_EMPTY, RP_OK, RP_E05} reply_type;
   typedef enum logic [2:0] {
      K_TX = 3'd0, K_STAGE = 3'd1, K_COMMIT = 3'd2, K_DISCARD = 3'd3, K_RUN = 3'd4
   } kind_type;

   // Result slots of one job, sent from the lowest set bit up.
   localparam int M_ST0  = 0;
   localparam int M_ST1  = 1;
   localparam int M_ACK  = 2;
   localparam int M_ACT  = 3;
   localparam int M_DOL  = 4;
   localparam int M_R1   = 5;
   localparam int M_R2   = 6;
   localparam int M_R3   = 7;
   localparam int M_HASH = 8;
   localparam int M_H1   = 9;
   localparam int M_H2   = 10;
   localparam int M_RUN  = 11;
   localparam int MASK_W = 12;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [7:0]        st0;
      logic [7:0]        st1;
      logic [6:0]        ix0;
      logic [6:0]        ix1;
      logic [7:0]        ack;
      kind_type          act;
      reply_type         rsel;
      logic [15:0]       waddr;
      logic [7:0]        wlen;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   // Hex digit value, or all ones for a byte that is not a hex digit.
   function automatic logic [7:0] nib_of(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
      else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
      else v = 8'hff;
      return v;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      return (v > 4'd9) ? (8'h57 + {4'h0, v}) : (8'h30 + {4'h0, v});
   endfunction

   // Body character of a reply at position 0..2.
   function automatic logic [7:0] reply_char(input reply_type r, input logic [1:0] p);
      logic [7:0] c;
      c = 8'h00;
      unique case (r)
         RP_OK:  c = (p == 2'd0) ? 8'h4f : 8'h4b;
         RP_E05: c = (p == 2'd0) ? 8'h45 : ((p == 2'd1) ? 8'h30 : 8'h35);
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] reply_sum(input reply_type r);
      logic [7:0] s;
      unique case (r)
         RP_OK:  s = 8'h9a;
         RP_E05: s = 8'haa;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   // Slot mask for a full reply frame.
   function automatic logic [MASK_W-1:0] reply_mask(input reply_type r);
      logic [MASK_W-1:0] m;
      m = '0;
      m[M_DOL] = 1'b1;
      m[M_HASH] = 1'b1;
      m[M_H1] = 1'b1;
      m[M_H2] = 1'b1;
      m[M_R1] = (r != RP_EMPTY);
      m[M_R2] = (r != RP_EMPTY);
      m[M_R3] = (r == RP_E05);
      return m;
   endfunction

endpackage

### hdl/dpbl_front.sv
module dpbl_front
   import dpbl_pkg::*;
#(
   parameter int STAGE_DEPTH = STAGE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [7:0]  in_byte,
   input  logic [31:0] space_mask,
   output logic        job_valid,
   output job_type     job
);

   localparam int SCW = $clog2(STAGE_DEPTH + 1);

   frame_type        frame_ff, frame_in;
   body_type         body_ff, body_in;
   reply_type        last_reply_ff, last_reply_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       csh_ff, csh_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [31:0]      addr_ff, addr_in;
   logic [31:0]      size_ff, size_in;
   logic [SCW-1:0]   cnt_ff, cnt_in;
   logic             esc_ff, esc_in;

   logic [7:0]       nib;
   logic [7:0]       cs;
   logic             two_req, one_req;
   logic [7:0]       sb0, sb1;
   logic             ok0, ok1;
   logic [SCW-1:0]   cnt1;
   logic             is_x;

   assign nib  = nib_of(in_byte);
   assign cs   = csh_ff | nib;
   assign is_x = (cmd_ff == CH_X);

   // Staging room for up to two data bytes from one received byte.
   assign ok0  = ({{(32-SCW){1'b0}}, cnt_ff} < size_ff) && (cnt_ff < SCW'(STAGE_DEPTH));
   assign cnt1 = cnt_ff + SCW'(ok0);
   assign ok1  = ({{(32-SCW){1'b0}}, cnt1} < size_ff) && (cnt1 < SCW'(STAGE_DEPTH));

   // Per-byte decode, next state and job build.
   always_comb begin
      frame_in = frame_ff;
      body_in = body_ff;
      last_reply_in = last_reply_ff;
      sum_in = sum_ff;
      csh_in = csh_ff;
      cmd_in = cmd_ff;
      addr_in = addr_ff;
      size_in = size_ff;
      cnt_in = cnt_ff;
      esc_in = esc_ff;
      one_req = 1'b0;
      two_req = 1'b0;
      sb0 = in_byte;
      sb1 = in_byte;
      job = '0;
      job.act = K_TX;
      job.rsel = RP_EMPTY;
      unique case (frame_ff)
         FR_IDLE: begin
            if (in_byte == CH_DOLLAR) begin
               frame_in = FR_BODY;
               sum_in = '0;
               cmd_in = '0;
               body_in = BP_CMD;
               addr_in = '0;
               size_in = '0;
               cnt_in = '0;
               esc_in = 1'b0;
            end else if (in_byte == CH_MINUS) begin
               job.rsel = last_reply_ff;
               job.mask = reply_mask(last_reply_ff);
            end else if (in_byte != CH_PLUS && in_byte != CH_ETX) begin
               job.rsel = RP_EMPTY;
               job.mask = reply_mask(RP_EMPTY);
               last_reply_in = RP_EMPTY;
            end
         end
         FR_BODY: begin
            if (in_byte == CH_HASH) begin
               if (esc_ff && is_x && body_ff == BP_DATA) begin
                  one_req = 1'b1;
                  sb0 = CH_ESC;
               end
               esc_in = 1'b0;
               frame_in = FR_CSH;
            end else begin
               sum_in = sum_ff + in_byte;
               unique case (body_ff)
                  BP_CMD: begin
                     cmd_in = in_byte;
                     body_in = (in_byte == CH_X) ? BP_ADDR : BP_DATA;
                  end
                  BP_ADDR: begin
                     if (nib == 8'hff) body_in = BP_SIZE;
                     else addr_in = {addr_ff[27:0], nib[3:0]};
                  end
                  BP_SIZE: begin
                     if (nib == 8'hff) body_in = BP_DATA;
                     else size_in = {size_ff[27:0], nib[3:0]};
                  end
                  default: begin
                     if (is_x) begin
                        if (esc_ff) begin
                           esc_in = 1'b0;
                           if (in_byte == 8'h03 || in_byte == 8'h04 ||
                               in_byte == 8'h5d || in_byte == 8'h0a) begin
                              one_req = 1'b1;
                              sb0 = in_byte | ESC_XOR;
                           end else if (in_byte == CH_ESC) begin
                              one_req = 1'b1;
                              sb0 = CH_ESC;
                              esc_in = 1'b1;
                           end else begin
                              two_req = 1'b1;
                              sb0 = CH_ESC;
                           end
                        end else if (in_byte == CH_ESC) begin
                           esc_in = 1'b1;
                        end else begin
                           one_req = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         FR_CSH: begin
            csh_in = {nib[3:0], 4'h0};
            frame_in = FR_CSL;
         end
         default: begin
            frame_in = FR_IDLE;
            job.ack = (cs == sum_ff) ? CH_PLUS : CH_MINUS;
            job.mask[M_ACK] = 1'b1;
            if (cs != sum_ff) begin
               job.act = K_DISCARD;
               job.mask[M_ACT] = is_x;
            end else if (is_x) begin
               job.mask[M_ACT] = 1'b1;
               if ((addr_ff & space_mask) == 32'h0) begin
                  job.act = K_COMMIT;
                  job.waddr = addr_ff[16:1] & ~space_mask[16:1];
                  job.wlen = 8'(cnt_ff);
                  job.rsel = RP_OK;
               end else begin
                  job.act = K_DISCARD;
                  job.rsel = RP_E05;
               end
               job.mask = job.mask | reply_mask(job.rsel);
               last_reply_in = job.rsel;
            end else begin
               job.rsel = (cmd_ff == CH_P || cmd_ff == CH_S || cmd_ff == CH_C) ?
                          RP_OK : RP_EMPTY;
               job.mask = job.mask | reply_mask(job.rsel);
               job.mask[M_RUN] = (cmd_ff == CH_S || cmd_ff == CH_C);
               last_reply_in = job.rsel;
            end
         end
      endcase
      // Staged bytes, dropped once the size or the buffer is used up.
      if (one_req || two_req) begin
         job.st0 = sb0;
         job.ix0 = 7'(cnt_ff);
         job.mask[M_ST0] = ok0;
         if (two_req) begin
            job.st1 = sb1;
            job.ix1 = 7'(cnt1);
            job.mask[M_ST1] = ok1;
            cnt_in = cnt1 + SCW'(ok1);
         end else begin
            cnt_in = cnt1;
         end
      end
   end

   assign job_valid = in_valid && (job.mask != '0);

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FR_IDLE;
         body_ff <= BP_CMD;
         last_reply_ff <= RP_EMPTY;
         sum_ff <= '0;
         csh_ff <= '0;
         cmd_ff <= '0;
         addr_ff <= '0;
         size_ff <= '0;
         cnt_ff <= '0;
         esc_ff <= 1'b0;
      end else if (in_valid) begin
         frame_ff <= frame_in;
         body_ff <= body_in;
         last_reply_ff <= last_reply_in;
         sum_ff <= sum_in;
         csh_ff <= csh_in;
         cmd_ff <= cmd_in;
         addr_ff <= addr_in;
         size_ff <= size_in;
         cnt_ff <= cnt_in;
         esc_ff <= esc_in;
      end
   end

endmodule

### hdl/dpbl_fifo.sv
module dpbl_fifo
   import dpbl_pkg::*;
#(
   parameter int WIDTH = JOB_W,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;

   assign head  = mem_ff[rd_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (AW+1)'(DEPTH));

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

endmodule

### hdl/dpbl_back.sv
module dpbl_back
   import dpbl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  job_type     q_head,
   output logic        q_pop,
   output logic        out_valid,
   input  logic        out_ready,
   output kind_type    out_kind,
   output logic [7:0]  out_byte,
   output logic [6:0]  out_index,
   output logic [15:0] out_waddr,
   output logic [7:0]  out_wlen,
   output logic        out_last
);

   job_type           job_ff;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [MASK_W-1:0] cur;
   logic [MASK_W-1:0] rest;
   logic [7:0]        sum;
   logic              load;

   // Lowest pending slot is the current result.
   assign cur  = mask_ff & (~mask_ff + 1'b1);
   assign rest = mask_ff & ~cur;
   assign sum  = reply_sum(job_ff.rsel);

   assign out_valid = (mask_ff != '0);
   assign out_last  = (rest == '0);
   assign load      = !out_valid || (out_ready && out_last);
   assign q_pop     = load && !q_empty;

   // Result fields for the current slot.
   always_comb begin
      out_kind = K_TX;
      out_byte = '0;
      out_index = '0;
      out_waddr = '0;
      out_wlen = '0;
      priority if (cur[M_ST0]) begin
         out_kind = K_STAGE;
         out_byte = job_ff.st0;
         out_index = job_ff.ix0;
      end else if (cur[M_ST1]) begin
         out_kind = K_STAGE;
         out_byte = job_ff.st1;
         out_index = job_ff.ix1;
      end else if (cur[M_ACK]) begin
         out_byte = job_ff.ack;
      end else if (cur[M_ACT]) begin
         out_kind = job_ff.act;
         if (job_ff.act == K_COMMIT) begin
            out_waddr = job_ff.waddr;
            out_wlen = job_ff.wlen;
         end
      end else if (cur[M_DOL]) begin
         out_byte = CH_DOLLAR;
      end else if (cur[M_R1]) begin
         out_byte = reply_char(job_ff.rsel, 2'd0);
      end else if (cur[M_R2]) begin
         out_byte = reply_char(job_ff.rsel, 2'd1);
      end else if (cur[M_R3]) begin
         out_byte = reply_char(job_ff.rsel, 2'd2);
      end else if (cur[M_HASH]) begin
         out_byte = CH_HASH;
      end else if (cur[M_H1]) begin
         out_byte = hex_char(sum[7:4]);
      end else if (cur[M_H2]) begin
         out_byte = hex_char(sum[3:0]);
      end else if (cur[M_RUN]) begin
         out_kind = K_RUN;
      end else begin
         out_kind = K_TX;
      end
   end

   // Slot mask: drop the sent slot, reload from the queue after the last one.
   always_comb begin
      mask_in = mask_ff;
      if (load) mask_in = q_empty ? '0 : q_head.mask;
      else if (out_ready) mask_in = rest;
   end

   always_ff @(posedge clock) begin
      if (reset) mask_ff <= '0;
      else mask_ff <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) job_ff <= q_head;
   end

endmodule

### hdl/debug_packet_binary_load.sv
// A received byte's job passes the job queue and then the result stage registers before
// its first result shows. Throughput: one received byte per cycle while the job queue has
// room; results leave at one per cycle while rsp_tready is high, up to nine per byte, so
// the result port sets the pace. Reset (synchronous, active high) returns the framer to
// idle, empties the queue, and sets space_mask to 0x00ff0000.
module debug_packet_binary_load
   import dpbl_pkg::*;
#(
   parameter int STAGE_DEPTH = STAGE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // byte_value, stage_index, word_address, write_length, pad
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data     // space_mask
);

   `include "debug_packet_binary_load_macros.svh"

   logic [31:0] space_mask_ff;
   logic        in_xfer;
   logic        job_valid;
   job_type     job_new, q_head;
   logic [JOB_W-1:0] q_head_bits;
   logic        q_empty, q_full, q_pop;
   kind_type    out_kind;
   logic [7:0]  out_byte;
   logic [6:0]  out_index;
   logic [15:0] out_waddr;
   logic [7:0]  out_wlen;

   // Configuration register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) space_mask_ff <= SPACE_MASK_RST;
      else if (csr_valid) space_mask_ff <= csr_data;
   end

   assign req_tready = !q_full;
   assign in_xfer = req_tvalid && req_tready;

   dpbl_front #(.STAGE_DEPTH(STAGE_DEPTH)) u_front (
      .clock(clock), .reset(reset), .in_valid(in_xfer), .in_byte(req_tdata),
      .space_mask(space_mask_ff), .job_valid(job_valid), .job(job_new)
   );

   dpbl_fifo #(.WIDTH(JOB_W), .DEPTH(4)) u_fifo (
      .clock(clock), .reset(reset), .push(job_valid), .push_data(job_new),
      .pop(q_pop), .head(q_head_bits), .empty(q_empty), .full(q_full)
   );

   assign q_head = job_type'(q_head_bits);

   dpbl_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_kind(out_kind),
      .out_byte(out_byte), .out_index(out_index), .out_waddr(out_waddr),
      .out_wlen(out_wlen), .out_last(rsp_tlast)
   );

   assign rsp_tuser = out_kind;
   assign rsp_tdata = {1'b0, out_wlen, out_waddr, out_index, out_byte};

   `DPBL_ASSERT(a_no_push_full, clock, reset, job_valid |-> !q_full, "job pushed into full queue")
   `DPBL_ASSERT(a_no_pop_empty, clock, reset, q_pop |-> !q_empty, "pop from empty queue")
   `DPBL_ASSERT(a_drain, clock, reset, (rsp_tvalid && rsp_tready && rsp_tlast && q_empty) |=> !rsp_tvalid, "result after drained queue")
   `DPBL_ASSERT(a_kind_range, clock, reset, !rsp_tvalid || (rsp_tuser <= K_RUN), "bad result kind")

endmodule
